>>> hw/rtl/gmhp_pkg.sv
// Package for the gzip member header parser.
// Holds opcodes, result codes, parser phases, queue sizing and the queue entry type.
// No dependencies.
package gmhp_pkg;

	// Input opcodes
	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_EOI  = 2'd1,
		OP_NEW  = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_HDR    = 3'd0,
		ST_BODY   = 3'd1,
		ST_TRANSP = 3'd2,
		ST_BAD    = 3'd3,
		ST_TRUNC  = 3'd4
	} status_t;

	// Parser phases
	typedef enum logic [3:0] {
		PH_MAGIC1    = 4'd0,
		PH_MAGIC2    = 4'd1,
		PH_METHOD    = 4'd2,
		PH_FLAGS     = 4'd3,
		PH_FIXED     = 4'd4,
		PH_XLEN_LO   = 4'd5,
		PH_XLEN_HI   = 4'd6,
		PH_EXTRA     = 4'd7,
		PH_NAME      = 4'd8,
		PH_COMMENT   = 4'd9,
		PH_HCRC      = 4'd10,
		PH_BODY      = 4'd11,
		PH_TRANSP    = 4'd12,
		PH_ERR_BAD   = 4'd13,
		PH_ERR_TRUNC = 4'd14
	} phase_t;

	// Header constants
	localparam logic [7:0]  MAGIC_ID1   = 8'h1F;
	localparam logic [7:0]  MAGIC_ID2   = 8'h8B;
	localparam logic [7:0]  CM_DEFLATE  = 8'h08;
	localparam logic [7:0]  FLG_RSVD    = 8'hE0;
	localparam logic [15:0] FIXED_LEN   = 16'd6;
	localparam logic [15:0] HCRC_LEN    = 16'd2;

	// Bit positions in the stored flag nibble (flag byte shifted right by one)
	localparam int FB_HCRC    = 0;
	localparam int FB_EXTRA   = 1;
	localparam int FB_NAME    = 2;
	localparam int FB_COMMENT = 3;

	// Optional sections, in header order
	typedef enum logic [2:0] {
		SEC_FIXED   = 3'd0,
		SEC_EXTRA   = 3'd1,
		SEC_NAME    = 3'd2,
		SEC_COMMENT = 3'd3,
		SEC_HCRC    = 3'd4
	} section_t;

	// Queue sizing
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One queue entry: one result, or a pair of transparent bytes
	typedef struct packed {
		logic       pair;
		status_t    status;
		logic [7:0] byte0;
		logic       valid0;
		logic       hdone;
		logic [7:0] byte1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		phase_t ph;
		logic   done;
	} adv_t;

	// Next phase after finishing section 'from'; done when the header is complete
	function automatic adv_t advance(input section_t from, input logic [3:0] flags);
		adv_t r;
		r.done = 1'b0;
		if (from < SEC_EXTRA && flags[FB_EXTRA]) begin
			r.ph = PH_XLEN_LO;
		end else if (from < SEC_NAME && flags[FB_NAME]) begin
			r.ph = PH_NAME;
		end else if (from < SEC_COMMENT && flags[FB_COMMENT]) begin
			r.ph = PH_COMMENT;
		end else if (from < SEC_HCRC && flags[FB_HCRC]) begin
			r.ph = PH_HCRC;
		end else begin
			r.ph   = PH_BODY;
			r.done = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/gmhp_feed_if.sv
// Input channel of the gzip member header parser: valid/ready plus opcode and byte.
// Standalone interface, no dependencies.
interface gmhp_feed_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] in_byte;

	modport source (output valid, output opcode, output in_byte, input ready);
	modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

>>> hw/rtl/gmhp_result_if.sv
// Result channel of the gzip member header parser: valid/ready plus result fields.
// Standalone interface, no dependencies.
interface gmhp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       header_done;
	logic       last;

	modport source (output valid, output status, output out_byte, output byte_valid,
		output header_done, output last, input ready);
	modport sink   (input valid, input status, input out_byte, input byte_valid,
		input header_done, input last, output ready);
endinterface

>>> hw/rtl/gzip_member_header_parser.sv
// gzip member header parser: top level.
// Depends on gmhp_pkg, gmhp_feed_if, gmhp_result_if, gmhp_front, gmhp_queue, gmhp_back.
//
// Usage:
//   feed   - one beat per stream event: opcode 0 carries in_byte, opcode 1 marks end
//            of input, opcode 2 restarts parsing at a new member (concatenated files).
//   result - zero, one or two result beats per feed beat. Header bytes come out as
//            status 0 (header_done on the last one), body bytes as status 1 with the
//            byte, transparent bytes as status 2. Status 3/4 report a bad header or a
//            truncated one; both are sticky until reset. last marks the final result
//            beat of a feed beat.
//   Throughput: one feed beat per cycle while the queue has room. A second magic byte
//            that does not match yields two result beats, which the back end emits
//            one after the other; the 4-entry queue absorbs it.
//   Path: a result passes the queue write, then the output register load, before it
//            appears at the output.
//   Stall: when result.ready is low, the output register holds and the queue fills;
//            feed.ready drops only once the queue is full.
//   Reset: arst_n clears the parser to expect the first magic byte, empties the
//            queue and drops result.valid.
module gzip_member_header_parser (
	input  logic           clk,
	input  logic           arst_n,
	gmhp_feed_if.sink      feed,
	gmhp_result_if.source  result
);

	gmhp_pkg::entry_t  push_entry;
	gmhp_pkg::entry_t  head;
	gmhp_pkg::qstat_t  qstat;
	logic              push;
	logic              pop;

	// Parser: classify each beat and queue its results
	gmhp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.qstat  (qstat),
		.push   (push),
		.entry  (push_entry)
	);

	// Decouple parser from the output stall
	gmhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	// Emit results, splitting byte pairs into two beats
	gmhp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	// A non-final result beat is always the first of a transparent pair
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=>
		result.valid && result.last && result.status == gmhp_pkg::ST_TRANSP)
		else $error("second beat of a transparent pair missing");

	// Forwarded bytes only on body or transparent status
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.byte_valid |->
		result.status == gmhp_pkg::ST_BODY || result.status == gmhp_pkg::ST_TRANSP)
		else $error("byte forwarded with non-data status");

	// Header end is a consumed header byte with no payload
	a_hdr_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.header_done |->
		result.status == gmhp_pkg::ST_HDR && !result.byte_valid)
		else $error("header_done on a non-header result");

	// No stray payload without byte_valid
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.byte_valid |-> result.out_byte == 8'd0)
		else $error("out_byte nonzero without byte_valid");

endmodule

>>> hw/rtl/gmhp_front.sv
// Front end: accepts input beats, runs the header state machine, queues results.
// Depends on gmhp_pkg and gmhp_feed_if.
module gmhp_front (
	input  logic              clk,
	input  logic              arst_n,
	gmhp_feed_if.sink         feed,
	input  gmhp_pkg::qstat_t  qstat,
	output logic              push,
	output gmhp_pkg::entry_t  entry
);

	gmhp_pkg::phase_t  phase_q, phase_d;
	logic [3:0]        flags_q, flags_d;
	logic [15:0]       skip_q, skip_d;
	logic [7:0]        held_q, held_d;
	logic              hdr_done;
	logic              accept;
	logic              err;
	logic [15:0]       skip_dec;
	logic [15:0]       xlen;
	gmhp_pkg::op_t     op;
	logic [7:0]        b;
	gmhp_pkg::adv_t    adv;

	assign feed.ready = !qstat.full;
	assign accept     = feed.valid && feed.ready;
	assign op         = gmhp_pkg::op_t'(feed.opcode);
	assign b          = feed.in_byte;
	assign err        = (phase_q == gmhp_pkg::PH_ERR_BAD) || (phase_q == gmhp_pkg::PH_ERR_TRUNC);
	assign skip_dec   = skip_q - 16'd1;
	assign xlen       = {b, skip_q[7:0]};

	// Next state
	always_comb begin
		phase_d  = phase_q;
		flags_d  = flags_q;
		skip_d   = skip_q;
		held_d   = held_q;
		hdr_done = 1'b0;
		adv      = '{ph: gmhp_pkg::PH_BODY, done: 1'b0};
		if (accept && !err) begin
			case (op)
				gmhp_pkg::OP_NEW: begin
					phase_d = gmhp_pkg::PH_MAGIC1;
					flags_d = '0;
					skip_d  = '0;
					held_d  = '0;
				end
				gmhp_pkg::OP_EOI: begin
					if (phase_q == gmhp_pkg::PH_MAGIC2) begin
						phase_d = gmhp_pkg::PH_TRANSP;
					end else if (!(phase_q inside {gmhp_pkg::PH_MAGIC1, gmhp_pkg::PH_BODY,
							gmhp_pkg::PH_TRANSP})) begin
						phase_d = gmhp_pkg::PH_ERR_TRUNC;
					end
				end
				gmhp_pkg::OP_DATA: begin
					case (phase_q)
						gmhp_pkg::PH_MAGIC1: begin
							if (b == gmhp_pkg::MAGIC_ID1) begin
								held_d  = b;
								phase_d = gmhp_pkg::PH_MAGIC2;
							end else begin
								phase_d = gmhp_pkg::PH_TRANSP;
							end
						end
						gmhp_pkg::PH_MAGIC2: begin
							phase_d = (b == gmhp_pkg::MAGIC_ID2) ? gmhp_pkg::PH_METHOD
								: gmhp_pkg::PH_TRANSP;
						end
						gmhp_pkg::PH_METHOD: begin
							held_d  = b;
							phase_d = gmhp_pkg::PH_FLAGS;
						end
						gmhp_pkg::PH_FLAGS: begin
							if (held_q != gmhp_pkg::CM_DEFLATE || (b & gmhp_pkg::FLG_RSVD) != 8'd0) begin
								phase_d = gmhp_pkg::PH_ERR_BAD;
							end else begin
								flags_d = b[4:1];
								skip_d  = gmhp_pkg::FIXED_LEN;
								phase_d = gmhp_pkg::PH_FIXED;
							end
						end
						gmhp_pkg::PH_FIXED: begin
							skip_d = skip_dec;
							if (skip_dec == 16'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_FIXED, flags_q);
							end
						end
						gmhp_pkg::PH_XLEN_LO: begin
							skip_d  = {8'd0, b};
							phase_d = gmhp_pkg::PH_XLEN_HI;
						end
						gmhp_pkg::PH_XLEN_HI: begin
							skip_d = xlen;
							if (xlen == 16'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_EXTRA, flags_q);
							end else begin
								phase_d = gmhp_pkg::PH_EXTRA;
							end
						end
						gmhp_pkg::PH_EXTRA: begin
							skip_d = skip_dec;
							if (skip_dec == 16'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_EXTRA, flags_q);
							end
						end
						gmhp_pkg::PH_NAME: begin
							if (b == 8'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_NAME, flags_q);
							end
						end
						gmhp_pkg::PH_COMMENT: begin
							if (b == 8'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_COMMENT, flags_q);
							end
						end
						gmhp_pkg::PH_HCRC: begin
							skip_d = skip_dec;
							if (skip_dec == 16'd0) begin
								adv = gmhp_pkg::advance(gmhp_pkg::SEC_HCRC, flags_q);
							end
						end
						default: begin
						end
					endcase
					// Apply a section change found above
					if (adv.done || adv.ph != gmhp_pkg::PH_BODY) begin
						phase_d  = adv.ph;
						hdr_done = adv.done;
						if (adv.ph == gmhp_pkg::PH_HCRC) begin
							skip_d = gmhp_pkg::HCRC_LEN;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Outputs: build the queue entry for this beat
	always_comb begin
		push  = 1'b0;
		entry = '{pair: 1'b0, status: gmhp_pkg::ST_HDR, byte0: 8'd0, valid0: 1'b0,
			hdone: 1'b0, byte1: 8'd0};
		if (accept) begin
			if (err) begin
				if (op == gmhp_pkg::OP_DATA || op == gmhp_pkg::OP_EOI || op == gmhp_pkg::OP_NEW) begin
					push         = 1'b1;
					entry.status = (phase_q == gmhp_pkg::PH_ERR_TRUNC) ? gmhp_pkg::ST_TRUNC
						: gmhp_pkg::ST_BAD;
				end
			end else begin
				case (op)
					gmhp_pkg::OP_EOI: begin
						if (phase_q == gmhp_pkg::PH_MAGIC2) begin
							push         = 1'b1;
							entry.status = gmhp_pkg::ST_TRANSP;
							entry.byte0  = held_q;
							entry.valid0 = 1'b1;
						end else if (!(phase_q inside {gmhp_pkg::PH_MAGIC1, gmhp_pkg::PH_BODY,
								gmhp_pkg::PH_TRANSP})) begin
							push         = 1'b1;
							entry.status = gmhp_pkg::ST_TRUNC;
						end
					end
					gmhp_pkg::OP_DATA: begin
						push = 1'b1;
						case (phase_q)
							gmhp_pkg::PH_MAGIC1: begin
								if (b != gmhp_pkg::MAGIC_ID1) begin
									entry.status = gmhp_pkg::ST_TRANSP;
									entry.byte0  = b;
									entry.valid0 = 1'b1;
								end
							end
							gmhp_pkg::PH_MAGIC2: begin
								if (b != gmhp_pkg::MAGIC_ID2) begin
									entry.pair   = 1'b1;
									entry.status = gmhp_pkg::ST_TRANSP;
									entry.byte0  = held_q;
									entry.valid0 = 1'b1;
									entry.byte1  = b;
								end
							end
							gmhp_pkg::PH_FLAGS: begin
								if (phase_d == gmhp_pkg::PH_ERR_BAD) begin
									entry.status = gmhp_pkg::ST_BAD;
								end
							end
							gmhp_pkg::PH_BODY: begin
								entry.status = gmhp_pkg::ST_BODY;
								entry.byte0  = b;
								entry.valid0 = 1'b1;
							end
							gmhp_pkg::PH_TRANSP: begin
								entry.status = gmhp_pkg::ST_TRANSP;
								entry.byte0  = b;
								entry.valid0 = 1'b1;
							end
							gmhp_pkg::PH_METHOD, gmhp_pkg::PH_FIXED, gmhp_pkg::PH_XLEN_LO,
							gmhp_pkg::PH_XLEN_HI, gmhp_pkg::PH_EXTRA, gmhp_pkg::PH_NAME,
							gmhp_pkg::PH_COMMENT, gmhp_pkg::PH_HCRC: begin
								entry.hdone = hdr_done;
							end
							default: begin
								entry.status = gmhp_pkg::ST_BAD;
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gmhp_pkg::PH_MAGIC1;
			flags_q <= '0;
			skip_q  <= '0;
			held_q  <= '0;
		end else begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			skip_q  <= skip_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> hw/rtl/gmhp_queue.sv
// Short result queue between the parser front end and the output back end.
// Depends on gmhp_pkg.
module gmhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gmhp_pkg::entry_t  wr_entry,
	input  logic              pop,
	output gmhp_pkg::entry_t  head,
	output gmhp_pkg::qstat_t  stat
);

	gmhp_pkg::entry_t                 slots_q [gmhp_pkg::Q_DEPTH];
	logic [gmhp_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [gmhp_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [gmhp_pkg::Q_CNT_W-1:0]     count_q;
	logic                             do_push;
	logic                             do_pop;

	assign stat.full  = (count_q == gmhp_pkg::Q_CNT_W'(gmhp_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/gmhp_back.sv
// Back end: drains queue entries, splits byte pairs, drives the output register.
// Depends on gmhp_pkg and gmhp_result_if.
module gmhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gmhp_pkg::entry_t  head,
	input  gmhp_pkg::qstat_t  qstat,
	output logic              pop,
	gmhp_result_if.source     result
);

	logic                valid_q;
	gmhp_pkg::status_t   status_q;
	logic [7:0]          byte_q;
	logic                bvalid_q;
	logic                hdone_q;
	logic                last_q;
	logic                pend_q;
	logic [7:0]          byte1_q;
	logic                load;

	assign load = !valid_q || result.ready;
	assign pop  = load && !pend_q && !qstat.empty;

	assign result.valid       = valid_q;
	assign result.status      = status_q;
	assign result.out_byte    = byte_q;
	assign result.byte_valid  = bvalid_q;
	assign result.header_done = hdone_q;
	assign result.last        = last_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !qstat.empty;
				pend_q  <= !qstat.empty && head.pair;
			end
		end
	end

	// Payload: second byte of a pair first, else the queue head
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				status_q <= gmhp_pkg::ST_TRANSP;
				byte_q   <= byte1_q;
				bvalid_q <= 1'b1;
				hdone_q  <= 1'b0;
				last_q   <= 1'b1;
			end else begin
				status_q <= head.status;
				byte_q   <= head.byte0;
				bvalid_q <= head.valid0;
				hdone_q  <= head.hdone;
				last_q   <= !head.pair;
				byte1_q  <= head.byte1;
			end
		end
	end

endmodule

>>> verif/gmhp_checker.sv
`timescale 1ns / 1ps
// Checker for the gzip member header parser: watches both channels, predicts result beats.
// Depends on gmhp_pkg, gmhp_feed_if and gmhp_result_if.
module gmhp_checker (
	input  logic   clk,
	input  logic   arst_n,
	gmhp_feed_if   feed,
	gmhp_result_if result,
	output int     fail_count,
	output int     pending,
	output int     result_count,
	output int     header_count,
	output int     forward_count,
	output int     error_count
);

	typedef struct packed {
		gmhp_pkg::status_t status;
		logic [7:0]        data;
		logic              data_valid;
		logic              hdr_done;
		logic              last;
	} result_beat_t;

	// Shadow parser state
	gmhp_pkg::phase_t parse_phase = gmhp_pkg::PH_MAGIC1;
	logic [3:0]       opt_flags   = 4'h0;
	logic [15:0]      skip_left   = 16'h0000;
	logic [7:0]       held        = 8'h00;
	logic             stuck       = 1'b0;

	result_beat_t due_results[$];
	int fails    = 0;
	int matched  = 0;
	int headers  = 0;
	int forwards = 0;
	int errors   = 0;

	function automatic void queue_result(input gmhp_pkg::status_t st, input logic [7:0] b,
		input logic v, input logic hd, input logic lst);
		result_beat_t r;
		r.status     = st;
		r.data       = v ? b : 8'h00;
		r.data_valid = v;
		r.hdr_done   = hd;
		r.last       = lst;
		due_results.push_back(r);
	endfunction

	// Leave an optional section; step to the next one the flags ask for, or into the body.
	function automatic logic close_section(input gmhp_pkg::section_t from);
		if (from < gmhp_pkg::SEC_EXTRA && opt_flags[gmhp_pkg::FB_EXTRA]) begin
			parse_phase = gmhp_pkg::PH_XLEN_LO;
			return 1'b0;
		end
		if (from < gmhp_pkg::SEC_NAME && opt_flags[gmhp_pkg::FB_NAME]) begin
			parse_phase = gmhp_pkg::PH_NAME;
			return 1'b0;
		end
		if (from < gmhp_pkg::SEC_COMMENT && opt_flags[gmhp_pkg::FB_COMMENT]) begin
			parse_phase = gmhp_pkg::PH_COMMENT;
			return 1'b0;
		end
		if (from < gmhp_pkg::SEC_HCRC && opt_flags[gmhp_pkg::FB_HCRC]) begin
			parse_phase = gmhp_pkg::PH_HCRC;
			skip_left   = gmhp_pkg::HCRC_LEN;
			return 1'b0;
		end
		parse_phase = gmhp_pkg::PH_BODY;
		return 1'b1;
	endfunction

	function automatic void clear_parser();
		parse_phase = gmhp_pkg::PH_MAGIC1;
		opt_flags   = 4'h0;
		skip_left   = 16'h0000;
		held        = 8'h00;
	endfunction

	task automatic parse_step(input logic [1:0] op, input logic [7:0] b);
		logic hd;
		hd = 1'b0;
		if (!(op == gmhp_pkg::OP_DATA || op == gmhp_pkg::OP_EOI || op == gmhp_pkg::OP_NEW))
			return;
		if (stuck) begin
			queue_result((parse_phase == gmhp_pkg::PH_ERR_TRUNC) ? gmhp_pkg::ST_TRUNC
				: gmhp_pkg::ST_BAD, 8'h00, 1'b0, 1'b0, 1'b1);
			return;
		end
		if (op == gmhp_pkg::OP_NEW) begin
			clear_parser();
			return;
		end
		if (op == gmhp_pkg::OP_EOI) begin
			case (parse_phase)
				gmhp_pkg::PH_MAGIC1, gmhp_pkg::PH_BODY, gmhp_pkg::PH_TRANSP: ;
				gmhp_pkg::PH_MAGIC2: begin
					parse_phase = gmhp_pkg::PH_TRANSP;
					queue_result(gmhp_pkg::ST_TRANSP, held, 1'b1, 1'b0, 1'b1);
				end
				default: begin
					parse_phase = gmhp_pkg::PH_ERR_TRUNC;
					stuck       = 1'b1;
					queue_result(gmhp_pkg::ST_TRUNC, 8'h00, 1'b0, 1'b0, 1'b1);
				end
			endcase
			return;
		end
		case (parse_phase)
			gmhp_pkg::PH_MAGIC1: begin
				if (b != gmhp_pkg::MAGIC_ID1) begin
					parse_phase = gmhp_pkg::PH_TRANSP;
					queue_result(gmhp_pkg::ST_TRANSP, b, 1'b1, 1'b0, 1'b1);
					return;
				end
				held        = b;
				parse_phase = gmhp_pkg::PH_MAGIC2;
			end
			gmhp_pkg::PH_MAGIC2: begin
				if (b != gmhp_pkg::MAGIC_ID2) begin
					parse_phase = gmhp_pkg::PH_TRANSP;
					queue_result(gmhp_pkg::ST_TRANSP, held, 1'b1, 1'b0, 1'b0);
					queue_result(gmhp_pkg::ST_TRANSP, b, 1'b1, 1'b0, 1'b1);
					return;
				end
				parse_phase = gmhp_pkg::PH_METHOD;
			end
			gmhp_pkg::PH_METHOD: begin
				held        = b;
				parse_phase = gmhp_pkg::PH_FLAGS;
			end
			gmhp_pkg::PH_FLAGS: begin
				if (held != gmhp_pkg::CM_DEFLATE || (b & gmhp_pkg::FLG_RSVD) != 8'h00) begin
					parse_phase = gmhp_pkg::PH_ERR_BAD;
					stuck       = 1'b1;
					queue_result(gmhp_pkg::ST_BAD, 8'h00, 1'b0, 1'b0, 1'b1);
					return;
				end
				opt_flags   = b[4:1];
				skip_left   = gmhp_pkg::FIXED_LEN;
				parse_phase = gmhp_pkg::PH_FIXED;
			end
			gmhp_pkg::PH_FIXED: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					hd = close_section(gmhp_pkg::SEC_FIXED);
			end
			gmhp_pkg::PH_XLEN_LO: begin
				skip_left   = {8'h00, b};
				parse_phase = gmhp_pkg::PH_XLEN_HI;
			end
			gmhp_pkg::PH_XLEN_HI: begin
				skip_left = {b, skip_left[7:0]};
				if (skip_left == 16'd0)
					hd = close_section(gmhp_pkg::SEC_EXTRA);
				else
					parse_phase = gmhp_pkg::PH_EXTRA;
			end
			gmhp_pkg::PH_EXTRA: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					hd = close_section(gmhp_pkg::SEC_EXTRA);
			end
			gmhp_pkg::PH_NAME: begin
				if (b == 8'h00)
					hd = close_section(gmhp_pkg::SEC_NAME);
			end
			gmhp_pkg::PH_COMMENT: begin
				if (b == 8'h00)
					hd = close_section(gmhp_pkg::SEC_COMMENT);
			end
			gmhp_pkg::PH_HCRC: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					hd = close_section(gmhp_pkg::SEC_HCRC);
			end
			gmhp_pkg::PH_BODY: begin
				queue_result(gmhp_pkg::ST_BODY, b, 1'b1, 1'b0, 1'b1);
				return;
			end
			gmhp_pkg::PH_TRANSP: begin
				queue_result(gmhp_pkg::ST_TRANSP, b, 1'b1, 1'b0, 1'b1);
				return;
			end
			default: begin
				queue_result(gmhp_pkg::ST_BAD, 8'h00, 1'b0, 1'b0, 1'b1);
				return;
			end
		endcase
		queue_result(gmhp_pkg::ST_HDR, 8'h00, 1'b0, hd, 1'b1);
	endtask

	function automatic string describe(input logic [2:0] st, input logic [7:0] b, input logic v,
		input logic hd, input logic lst);
		return $sformatf("status=%0d out_byte=%02h byte_valid=%b header_done=%b last=%b",
			st, b, v, hd, lst);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		string        got_s;
		if (!arst_n) begin
			stuck = 1'b0;
			clear_parser();
			due_results.delete();
		end else begin
			// Results of this edge's feed beat cannot show up yet, so compare first.
			if (result.valid && result.ready) begin
				got_s = describe(result.status, result.out_byte, result.byte_valid,
					result.header_done, result.last);
				if (due_results.size() == 0) begin
					fails++;
					$display("%0t: result beat with nothing due: expected no beat, got %s",
						$time, got_s);
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status || result.out_byte !== want.data ||
						result.byte_valid !== want.data_valid ||
						result.header_done !== want.hdr_done || result.last !== want.last) begin
						fails++;
						$display("%0t: result mismatch: expected %s, got %s", $time,
							describe(want.status, want.data, want.data_valid, want.hdr_done,
								want.last), got_s);
					end else begin
						matched++;
						if (want.hdr_done)
							headers++;
						if (want.data_valid)
							forwards++;
						if (want.status == gmhp_pkg::ST_BAD || want.status == gmhp_pkg::ST_TRUNC)
							errors++;
					end
				end
			end
			if (feed.valid && feed.ready)
				parse_step(feed.opcode, feed.in_byte);
		end
		fail_count    <= fails;
		pending       <= due_results.size();
		result_count  <= matched;
		header_count  <= headers;
		forward_count <= forwards;
		error_count   <= errors;
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the gzip member header parser testbench: clock, reset, feed stimulus, result stalls.
// Depends on gmhp_pkg, both channel interfaces, gzip_member_header_parser and gmhp_checker.
module testbench;

	// Opcode 3 has no meaning; the parser must drop it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_BEATS = 1100;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_XLEN    = 400;

	// First member of the directed part: every optional flag plus FTEXT, empty extra
	// field, empty name, empty comment, header CRC, then two body bytes.
	localparam logic [7:0] DIRECTED_MEMBER [18] = '{
		8'h1F, 8'h8B, 8'h08, 8'h1F,
		8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h01,
		8'h00, 8'h00,
		8'h00,
		8'h00,
		8'hFF, 8'h00,
		8'hFF, 8'h00
	};

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_LONG} ready_mode_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} feed_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	feed_beat_t feed_script[$];
	logic [7:0] hdr_bytes[$];

	int    full_members   = 0;
	int    cut_headers    = 0;
	int    plain_streams  = 0;
	int    fed_beats      = 0;
	string tail_kind      = "";

	int fail_count;
	int pending_count;
	int result_count;
	int header_count;
	int forward_count;
	int error_count;

	gmhp_feed_if   feed_if();
	gmhp_result_if res_if();

	gzip_member_header_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if),
		.result (res_if)
	);

	gmhp_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.feed          (feed_if),
		.result        (res_if),
		.fail_count    (fail_count),
		.pending       (pending_count),
		.result_count  (result_count),
		.header_count  (header_count),
		.forward_count (forward_count),
		.error_count   (error_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] rand_octet();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	function automatic logic [7:0] rand_nonzero();
		logic [7:0] r;
		r = rand_octet();
		if (r == 8'h00)
			r = 8'h01;
		return r;
	endfunction

	// Any byte except v; used to break the magic pair or the method on purpose.
	function automatic logic [7:0] other_than(input logic [7:0] v);
		logic [7:0] r;
		r = rand_octet();
		if (r == v)
			r = r + 8'd1;
		return r;
	endfunction

	// Mostly short extra fields, some medium, a few with the high length byte set.
	function automatic int pick_xlen();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6);
		if (r < 95)
			return $urandom_range(7, 40);
		return $urandom_range(256, 300);
	endfunction

	function automatic void script_add(input logic [1:0] op, input logic [7:0] data);
		feed_beat_t fb;
		fb.op   = op;
		fb.data = data;
		feed_script.push_back(fb);
	endfunction

	// Queue one beat; now and then slip an unused opcode in front of it.
	function automatic void push_beat(input logic [1:0] op, input logic [7:0] data);
		if ($urandom_range(0, 40) == 0)
			script_add(OP_UNUSED, rand_octet());
		script_add(op, data);
	endfunction

	// Build a well-formed header in hdr_bytes. flg holds flag byte bits 4..0.
	function automatic void build_header(input logic [4:0] flg, input int xlen);
		int          k;
		logic [15:0] xl;
		xl = xlen[15:0];
		hdr_bytes.delete();
		hdr_bytes.push_back(gmhp_pkg::MAGIC_ID1);
		hdr_bytes.push_back(gmhp_pkg::MAGIC_ID2);
		hdr_bytes.push_back(gmhp_pkg::CM_DEFLATE);
		hdr_bytes.push_back({3'b000, flg});
		// mtime, extra flags, OS
		for (k = 0; k < gmhp_pkg::FIXED_LEN; k++)
			hdr_bytes.push_back(rand_octet());
		if (flg[gmhp_pkg::FB_EXTRA + 1]) begin
			hdr_bytes.push_back(xl[7:0]);
			hdr_bytes.push_back(xl[15:8]);
			for (k = 0; k < xlen; k++)
				hdr_bytes.push_back(rand_octet());
		end
		if (flg[gmhp_pkg::FB_NAME + 1]) begin
			repeat ($urandom_range(0, 6))
				hdr_bytes.push_back(rand_nonzero());
			hdr_bytes.push_back(8'h00);
		end
		if (flg[gmhp_pkg::FB_COMMENT + 1]) begin
			repeat ($urandom_range(0, 6))
				hdr_bytes.push_back(rand_nonzero());
			hdr_bytes.push_back(8'h00);
		end
		if (flg[gmhp_pkg::FB_HCRC + 1]) begin
			hdr_bytes.push_back(rand_octet());
			hdr_bytes.push_back(rand_octet());
		end
	endfunction

	function automatic void push_header(input int count);
		int k;
		for (k = 0; k < count; k++)
			push_beat(gmhp_pkg::OP_DATA, hdr_bytes[k]);
	endfunction

	// Body or transparent bytes, with an occasional end of input mixed in (harmless there).
	function automatic void push_stream(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 30) == 0)
				push_beat(gmhp_pkg::OP_EOI, rand_octet());
			push_beat(gmhp_pkg::OP_DATA, rand_octet());
		end
	endfunction

	function automatic void add_directed();
		int k;
		script_add(gmhp_pkg::OP_EOI, 8'h00);       // end of input before any header byte
		script_add(gmhp_pkg::OP_NEW, 8'hFF);       // new member while idle
		for (k = 0; k < 18; k++)
			script_add(gmhp_pkg::OP_DATA, DIRECTED_MEMBER[k]);
		script_add(gmhp_pkg::OP_EOI, 8'hFF);       // end of input inside the body
		script_add(gmhp_pkg::OP_NEW, 8'h00);
		script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
		script_add(gmhp_pkg::OP_EOI, 8'h00);       // held first magic byte comes back out
		script_add(gmhp_pkg::OP_DATA, 8'hFF);      // transparent from here
		script_add(gmhp_pkg::OP_EOI, 8'h00);
		script_add(gmhp_pkg::OP_NEW, 8'h00);
		script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
		script_add(gmhp_pkg::OP_DATA, 8'h00);      // second magic byte wrong: two beats
		script_add(gmhp_pkg::OP_NEW, 8'h00);
		script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID2);  // first magic byte wrong
		script_add(OP_UNUSED, 8'hFF);
	endfunction

	function automatic void add_full_member(input logic [4:0] flg, input int xlen);
		push_beat(gmhp_pkg::OP_NEW, rand_octet());
		build_header(flg, xlen);
		push_header(hdr_bytes.size());
		push_stream($urandom_range(0, 24));
		full_members++;
	endfunction

	function automatic void add_random();
		int target;
		int pick;
		int k;
		target = feed_script.size() + RANDOM_BEATS;
		while (feed_script.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				add_full_member(5'($urandom_range(0, 31)), pick_xlen());
			end else if (pick < 72) begin
				// header dropped partway by a new-member beat; the next scenario opens with one
				push_beat(gmhp_pkg::OP_NEW, rand_octet());
				build_header(5'($urandom_range(0, 31)), pick_xlen());
				push_header($urandom_range(1, hdr_bytes.size() - 1));
				cut_headers++;
			end else if (pick < 85) begin
				push_beat(gmhp_pkg::OP_NEW, rand_octet());
				case ($urandom_range(0, 2))
					0: push_beat(gmhp_pkg::OP_DATA, other_than(gmhp_pkg::MAGIC_ID1));
					1: begin
						push_beat(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
						push_beat(gmhp_pkg::OP_DATA, other_than(gmhp_pkg::MAGIC_ID2));
					end
					default: begin
						push_beat(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
						push_beat(gmhp_pkg::OP_EOI, rand_octet());
					end
				endcase
				push_stream($urandom_range(0, 20));
				plain_streams++;
			end else begin
				// noise on a transparent stream: bytes, stray ends of input, unused opcodes
				push_beat(gmhp_pkg::OP_NEW, rand_octet());
				push_beat(gmhp_pkg::OP_DATA, other_than(gmhp_pkg::MAGIC_ID1));
				for (k = $urandom_range(4, 20); k > 0; k--) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: push_beat(gmhp_pkg::OP_DATA, rand_octet());
						6, 7:             push_beat(gmhp_pkg::OP_EOI, rand_octet());
						default:          script_add(OP_UNUSED, rand_octet());
					endcase
				end
				plain_streams++;
			end
		end
		// one member with a long extra field
		add_full_member(5'($urandom_range(0, 31)) | 5'b00100, LONG_XLEN);
	endfunction

	// The error is sticky until reset, and reset comes only once, so it closes the run.
	function automatic void add_error_tail();
		int k;
		script_add(gmhp_pkg::OP_NEW, rand_octet());
		case ($urandom_range(0, 2))
			0: begin
				tail_kind = "bad method";
				script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
				script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID2);
				script_add(gmhp_pkg::OP_DATA, other_than(gmhp_pkg::CM_DEFLATE));
				script_add(gmhp_pkg::OP_DATA, rand_octet());
			end
			1: begin
				tail_kind = "reserved flag bits";
				script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID1);
				script_add(gmhp_pkg::OP_DATA, gmhp_pkg::MAGIC_ID2);
				script_add(gmhp_pkg::OP_DATA, gmhp_pkg::CM_DEFLATE);
				script_add(gmhp_pkg::OP_DATA,
					{3'($urandom_range(1, 7)), 5'($urandom_range(0, 31))});
			end
			default: begin
				tail_kind = "truncated header";
				build_header(5'($urandom_range(0, 31)) | 5'b11110, $urandom_range(0, 4));
				push_header($urandom_range(2, hdr_bytes.size() - 1));
				script_add(gmhp_pkg::OP_EOI, rand_octet());
			end
		endcase
		for (k = 0; k < 24; k++)
			script_add(2'($urandom_range(0, 3)), rand_octet());
	endfunction

	// Feed driver: bursts of random length, random gaps, some long gap-free stretches.
	initial begin
		feed_beat_t cur;
		int         burst;
		int         gap;
		feed_if.valid   <= 1'b0;
		feed_if.opcode  <= gmhp_pkg::OP_DATA;
		feed_if.in_byte <= 8'h00;
		add_directed();
		add_random();
		add_error_tail();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst = $urandom_range(1, 40);
		gap   = 0;
		while (feed_script.size() != 0) begin
			if (gap != 0) begin
				// idle: drop valid and put junk on the payload
				feed_if.valid   <= 1'b0;
				feed_if.opcode  <= 2'($urandom_range(0, 3));
				feed_if.in_byte <= rand_octet();
				gap--;
				@(posedge clk);
			end else begin
				cur = feed_script[0];
				feed_if.valid   <= 1'b1;
				feed_if.opcode  <= cur.op;
				feed_if.in_byte <= cur.data;
				@(posedge clk);
				// hold the beat until the parser takes it
				while (!feed_if.ready)
					@(posedge clk);
				void'(feed_script.pop_front());
				fed_beats++;
				burst--;
				if (burst == 0) begin
					burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
					gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		feed_if.valid <= 1'b0;
		@(posedge clk);
		// drain: wait for every predicted beat, then a few more cycles for strays
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Fed %0d beats: %0d full members (one with a %0d-byte extra field), %0d cut headers,",
			fed_beats, full_members, LONG_XLEN, cut_headers);
		$display("  %0d transparent/noise streams, then a %s; %0d result beats matched",
			plain_streams, tail_kind, result_count);
		$display("  (%0d headers done, %0d bytes forwarded, %0d error reports).",
			header_count, forward_count, error_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (pending_count != 0)
				$display("%0t: %0d predicted result beats never arrived", $time, pending_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Result receiver: stall on its own pattern, switching to a random mode after each random span.
	initial begin
		ready_mode_t mode;
		int          span;
		int          k;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					RDY_ALWAYS:   res_if.ready <= 1'b1;
					RDY_COIN:     res_if.ready <= ($urandom_range(0, 1) == 1);
					RDY_PERIODIC: res_if.ready <= ((k % 4) != 0);
					default:      res_if.ready <= (((k / 12) % 2) == 1);
				endcase
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((feed_if.valid && feed_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
